@@ rtl/relosc_pkg.sv @@
// Shared constants, codes and the controller-to-datapath command type for the
// relaxation oscillator step block. No dependencies.
`timescale 1ns / 1ps

package relosc_pkg;

	localparam int DATA_WIDTH       = 24;
	localparam int FRAC_BITS        = 16;
	localparam int TANH_ENTRIES_DEF = 64;
	localparam int KIND_W           = 2;
	localparam int STEP_W           = 17;
	localparam int CFG_AW           = 1;

	localparam int ONE_Q   = 1 << FRAC_BITS;
	localparam int K_TENTH = ((1 << FRAC_BITS) + 5) / 10;
	localparam int K_004   = ((4 << FRAC_BITS) + 50) / 100;
	localparam int K_002   = ((2 << FRAC_BITS) + 50) / 100;
	localparam int ST_MAX  = (1 << (DATA_WIDTH - 1)) - 1;
	localparam int ST_MIN  = -(1 << (DATA_WIDTH - 1));

	localparam logic [KIND_W-1:0] KIND_COUPLE = 2'd0;
	localparam logic [KIND_W-1:0] KIND_STEP   = 2'd1;
	localparam logic [KIND_W-1:0] KIND_POT    = 2'd2;

	localparam logic [CFG_AW-1:0] REG_INPUT_VALUE = 1'd0;
	localparam logic [CFG_AW-1:0] REG_STEP_SIZE   = 1'd1;

	localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(K_TENTH);

	// shared multiplier operand selects
	localparam int MSEL_W = 3;
	localparam logic [MSEL_W-1:0] MUL_XX   = 3'd0;
	localparam logic [MSEL_W-1:0] MUL_CUBE = 3'd1;
	localparam logic [MSEL_W-1:0] MUL_DYK  = 3'd2;
	localparam logic [MSEL_W-1:0] MUL_DXL  = 3'd3;
	localparam logic [MSEL_W-1:0] MUL_DXH  = 3'd4;
	localparam logic [MSEL_W-1:0] MUL_DYH  = 3'd5;
	localparam logic [MSEL_W-1:0] MUL_PK   = 3'd6;
	localparam logic [MSEL_W-1:0] MUL_PH   = 3'd7;

	typedef struct packed {
		logic              load_item;
		logic              mul_en;
		logic [MSEL_W-1:0] mul_sel;
		logic              ld_base;
		logic              ld_dx;
		logic              ld_dy;
		logic              ld_lo;
		logic              ld_nx;
		logic              ld_dp;
		logic              commit;
	} dp_cmd_t;

endpackage

@@ rtl/relosc_ctrl.sv @@
// Sequencer for the oscillator step: walks each request through the shared
// multiplier schedule and owns the result valid. Uses relosc_pkg.
`timescale 1ns / 1ps

module relosc_ctrl import relosc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [KIND_W-1:0] kind,
	output logic              out_valid,
	input  logic              out_ready,
	output dp_cmd_t           cmd
);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_SQ   = 4'd1;
	localparam logic [3:0] S_CUBE = 4'd2;
	localparam logic [3:0] S_DYK  = 4'd3;
	localparam logic [3:0] S_DXL  = 4'd4;
	localparam logic [3:0] S_DXH  = 4'd5;
	localparam logic [3:0] S_DY   = 4'd6;
	localparam logic [3:0] S_PK   = 4'd7;
	localparam logic [3:0] S_PD   = 4'd8;
	localparam logic [3:0] S_PH   = 4'd9;
	localparam logic [3:0] S_WB   = 4'd10;

	logic [3:0] state_q, state_d;
	logic       out_valid_q;
	logic       accept;
	logic       slot_free;

	assign in_ready  = (state_q == S_IDLE);
	assign accept    = in_valid && in_ready;
	assign slot_free = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					cmd.load_item = 1'b1;
					unique case (kind)
						KIND_STEP: state_d = S_SQ;
						KIND_POT:  state_d = S_PK;
						default:   state_d = S_WB;
					endcase
				end
			end
			S_SQ: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_XX;
				cmd.ld_base = 1'b1;
				state_d     = S_CUBE;
			end
			S_CUBE: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_CUBE;
				state_d     = S_DYK;
			end
			S_DYK: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_DYK;
				cmd.ld_dx   = 1'b1;
				state_d     = S_DXL;
			end
			S_DXL: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_DXL;
				cmd.ld_dy   = 1'b1;
				state_d     = S_DXH;
			end
			S_DXH: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_DXH;
				cmd.ld_lo   = 1'b1;
				state_d     = S_DY;
			end
			S_DY: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_DYH;
				cmd.ld_nx   = 1'b1;
				state_d     = S_WB;
			end
			S_PK: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_PK;
				state_d     = S_PD;
			end
			S_PD: begin
				cmd.ld_dp = 1'b1;
				state_d   = S_PH;
			end
			S_PH: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_PH;
				state_d     = S_WB;
			end
			S_WB: begin
				if (slot_free) begin
					cmd.commit = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_commit_slot: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> (!out_valid_q || out_ready))
		else $error("result written over a pending one");

	a_step_entry: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && kind == KIND_STEP) |=> (state_q == S_SQ))
		else $error("step request did not start the multiply chain");

	a_valid_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(cmd.commit))
		else $error("result valid without a commit");

	a_wb_exit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WB && slot_free) |=> (state_q == S_IDLE))
		else $error("write-back stalled with a free slot");

endmodule

@@ rtl/relosc_dp.sv @@
// Datapath: oscillator state, config registers, tanh table, one shared
// 33x25 multiplier and the saturating write-back. Uses relosc_pkg.
`timescale 1ns / 1ps

module relosc_dp import relosc_pkg::*; #(
	parameter int TANH_ENTRIES = TANH_ENTRIES_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  dp_cmd_t                      cmd,
	input  logic [KIND_W-1:0]            kind,
	input  logic signed [DATA_WIDTH-1:0] coupling_weight,
	input  logic signed [DATA_WIDTH-1:0] global_inhibition,
	input  logic                         last_weight,
	input  logic signed [DATA_WIDTH-1:0] noise_sample,
	input  logic                         lateral_nonnegative,
	input  logic                         cfg_we,
	input  logic [CFG_AW-1:0]            cfg_index,
	input  logic [DATA_WIDTH-1:0]        cfg_data,
	output logic signed [DATA_WIDTH-1:0] excitation_out,
	output logic signed [DATA_WIDTH-1:0] inhibition_out,
	output logic signed [DATA_WIDTH-1:0] potential_out,
	output logic                         saturated
);

	localparam int MUL_AW = 33;
	localparam int MUL_BW = 25;
	localparam int MUL_PW = MUL_AW + MUL_BW;
	localparam int WG_W   = DATA_WIDTH + 1;
	localparam int ADJ_W  = DATA_WIDTH + 2;
	localparam int BASE_W = DATA_WIDTH + 4;
	localparam int DX_W   = 41;
	localparam int DYA_W  = DATA_WIDTH + 3;
	localparam int DY_W   = DATA_WIDTH;
	localparam int LO_W   = STEP_W + 1;
	localparam int NX_W   = 45;
	localparam int DP_W   = DATA_WIDTH + 3;
	localparam int TAB_AW = $clog2(TANH_ENTRIES);
	localparam int T_W    = FRAC_BITS + 2;
	localparam int TSCALE = 10 * TANH_ENTRIES;
	localparam int TIDX_W = DATA_WIDTH + $clog2(TSCALE + 1);
	localparam longint unsigned Q20 = 64'd1 << 20;
	localparam longint unsigned TANH_D = (64'd8 * Q20) / TANH_ENTRIES;

	typedef logic [FRAC_BITS-1:0] tanh_tab_t [TANH_ENTRIES];

	typedef struct packed {
		logic                         hit;
		logic signed [DATA_WIDTH-1:0] val;
	} sat_t;

	// restoring shift-subtract division, used only while the table is built
	function automatic longint unsigned div_u64(input longint unsigned num,
			input longint unsigned den);
		longint unsigned q;
		longint unsigned r;
		q = '0;
		r = '0;
		for (int b = 63; b >= 0; b--) begin
			r = {r[62:0], num[b]};
			if (r >= den) begin
				r    = r - den;
				q[b] = 1'b1;
			end
		end
		return q;
	endfunction

	// tanh(4i/N) from an integer exponential series in Q20
	function automatic tanh_tab_t build_tanh();
		longint unsigned term;
		longint unsigned ed;
		longint unsigned e;
		tanh_tab_t       tab;
		term = Q20;
		ed   = Q20;
		e    = Q20;
		for (int k = 1; k <= 15; k++) begin
			term = div_u64(term * TANH_D, 64'(k) * Q20);
			ed   = ed + term;
		end
		for (int i = 0; i < TANH_ENTRIES; i++) begin
			tab[i] = FRAC_BITS'(div_u64((e - Q20) << FRAC_BITS, e + Q20));
			e      = (e * ed) >> 20;
		end
		return tab;
	endfunction

	localparam tanh_tab_t TANH_TAB = build_tanh();

	function automatic sat_t sat_state(input logic signed [NX_W-1:0] v);
		sat_t r;
		r.hit = 1'b0;
		r.val = v[DATA_WIDTH-1:0];
		if (v > NX_W'(ST_MAX)) begin
			r.hit = 1'b1;
			r.val = DATA_WIDTH'(ST_MAX);
		end else if (v < NX_W'(ST_MIN)) begin
			r.hit = 1'b1;
			r.val = DATA_WIDTH'(ST_MIN);
		end
		return r;
	endfunction

	// architectural state and config
	logic signed [DATA_WIDTH-1:0] x_q, y_q, p_q, pc_q, ac_q, iv_q;
	logic [STEP_W-1:0]            h_q;

	// per-request working registers
	logic [KIND_W-1:0]        kind_q;
	logic                     last_q, lat_q;
	logic signed [WG_W-1:0]   wg_q;
	logic signed [ADJ_W-1:0]  adj_q;
	logic signed [BASE_W-1:0] base_q;
	logic signed [DYA_W-1:0]  dyarg_q;
	logic signed [DX_W-1:0]   dx_q;
	logic signed [DY_W-1:0]   dy_q;
	logic [LO_W-1:0]          lo_q;
	logic signed [NX_W-1:0]   nx_q;
	logic signed [DP_W-1:0]   dp_q;
	logic signed [MUL_PW-1:0] prod_q;

	logic signed [DATA_WIDTH-1:0] ex_out_q, in_out_q, po_out_q;
	logic                         sat_out_q;

	// combinational
	logic signed [DATA_WIDTH-1:0] iv_sel;
	logic signed [ADJ_W-1:0]      adj_d;
	logic [DATA_WIDTH-1:0]        mag;
	logic [TIDX_W-1:0]            idx_full;
	logic                         in_tab;
	logic signed [T_W-1:0]        t_mag, t_sgn;
	logic signed [DYA_W-1:0]      onept, dyarg_d;
	logic signed [BASE_W-1:0]     bx, base_d;
	logic signed [MUL_PW-1:0]     prod_sh;
	logic signed [DX_W-1:0]       dxh;
	logic signed [MUL_AW-1:0]     mul_a;
	logic signed [MUL_BW-1:0]     mul_b, hb;
	logic signed [NX_W-1:0]       prod_add, ny_w, np_w, psum_w;
	logic signed [DP_W-1:0]       dp_lat;
	sat_t                         sx, sy, sp, sc;
	logic signed [DATA_WIDTH-1:0] x_n, y_n, p_n, pc_n, ac_n;
	logic                         hit_n;

	assign iv_sel = (p_q > DATA_WIDTH'(K_TENTH)) ? iv_q : '0;
	assign adj_d  = ADJ_W'(iv_sel) + ADJ_W'(ac_q) + ADJ_W'(noise_sample);

	// tanh(x/0.1) lookup, odd symmetry
	assign mag      = x_q[DATA_WIDTH-1] ? (~x_q + 1'b1) : x_q;
	assign idx_full = (TIDX_W'(mag) * TIDX_W'(TSCALE)) >> (FRAC_BITS + 2);
	assign in_tab   = idx_full < TIDX_W'(TANH_ENTRIES);
	assign t_mag    = in_tab ? $signed({2'b00, TANH_TAB[idx_full[TAB_AW-1:0]]})
	                         : T_W'(ONE_Q);
	assign t_sgn    = x_q[DATA_WIDTH-1] ? -t_mag : t_mag;
	assign onept    = DYA_W'(ONE_Q) + DYA_W'(t_sgn);
	assign dyarg_d  = (onept * DYA_W'(9)) - DYA_W'(y_q);

	assign bx     = BASE_W'(x_q);
	assign base_d = bx + bx + bx - BASE_W'(y_q) + BASE_W'(adj_q) + BASE_W'(2 * ONE_Q);

	assign prod_sh  = prod_q >>> FRAC_BITS;
	assign dxh      = dx_q >>> FRAC_BITS;
	assign hb       = $signed({{(MUL_BW - STEP_W){1'b0}}, h_q});
	assign prod_add = $signed(prod_sh[NX_W-1:0]);
	assign dp_lat   = lat_q ? (DP_W'(ONE_Q) - DP_W'(p_q)) : '0;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (cmd.mul_sel)
			MUL_XX: begin
				mul_a = MUL_AW'(x_q);
				mul_b = MUL_BW'(x_q);
			end
			MUL_CUBE: begin
				mul_a = $signed(prod_sh[MUL_AW-1:0]);
				mul_b = MUL_BW'(x_q);
			end
			MUL_DYK: begin
				mul_a = MUL_AW'(dyarg_q);
				mul_b = MUL_BW'(K_004);
			end
			MUL_DXL: begin
				mul_a = $signed({{(MUL_AW - FRAC_BITS){1'b0}}, dx_q[FRAC_BITS-1:0]});
				mul_b = hb;
			end
			MUL_DXH: begin
				mul_a = $signed(dxh[MUL_AW-1:0]);
				mul_b = hb;
			end
			MUL_DYH: begin
				mul_a = MUL_AW'(dy_q);
				mul_b = hb;
			end
			MUL_PK: begin
				mul_a = MUL_AW'(p_q);
				mul_b = MUL_BW'(K_002);
			end
			MUL_PH: begin
				mul_a = MUL_AW'(dp_q);
				mul_b = hb;
			end
		endcase
	end

	// write-back
	assign ny_w   = NX_W'(y_q) + prod_add;
	assign np_w   = NX_W'(p_q) + prod_add;
	assign psum_w = NX_W'(pc_q) + NX_W'(wg_q);
	assign sx     = sat_state(nx_q);
	assign sy     = sat_state(ny_w);
	assign sp     = sat_state(np_w);
	assign sc     = sat_state(psum_w);

	always_comb begin
		x_n   = x_q;
		y_n   = y_q;
		p_n   = p_q;
		pc_n  = pc_q;
		ac_n  = ac_q;
		hit_n = 1'b0;
		unique case (kind_q)
			KIND_COUPLE: begin
				hit_n = sc.hit;
				if (last_q) begin
					ac_n = sc.val;
					pc_n = '0;
				end else begin
					pc_n = sc.val;
				end
			end
			KIND_STEP: begin
				x_n   = sx.val;
				y_n   = sy.val;
				hit_n = sx.hit | sy.hit;
			end
			KIND_POT: begin
				p_n   = sp.val;
				hit_n = sp.hit;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q  <= '0;
			y_q  <= '0;
			p_q  <= '0;
			pc_q <= '0;
			ac_q <= '0;
			iv_q <= '0;
			h_q  <= STEP_RESET;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_INPUT_VALUE: iv_q <= $signed(cfg_data);
					REG_STEP_SIZE:   h_q  <= cfg_data[STEP_W-1:0];
				endcase
			end
			if (cmd.commit) begin
				x_q  <= x_n;
				y_q  <= y_n;
				p_q  <= p_n;
				pc_q <= pc_n;
				ac_q <= ac_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			kind_q <= kind;
			last_q <= last_weight;
			lat_q  <= lateral_nonnegative;
			wg_q   <= WG_W'(coupling_weight) - WG_W'(global_inhibition);
			adj_q  <= adj_d;
		end
		if (cmd.mul_en) begin
			prod_q <= mul_a * mul_b;
		end
		if (cmd.ld_base) begin
			base_q  <= base_d;
			dyarg_q <= dyarg_d;
		end
		if (cmd.ld_dx) begin
			dx_q <= DX_W'(base_q) - $signed(prod_sh[DX_W-1:0]);
		end
		if (cmd.ld_dy) begin
			dy_q <= $signed(prod_sh[DY_W-1:0]);
		end
		if (cmd.ld_lo) begin
			lo_q <= prod_sh[LO_W-1:0];
		end
		if (cmd.ld_nx) begin
			nx_q <= $signed(prod_q[NX_W-1:0]) + NX_W'(x_q)
			        + $signed({{(NX_W - LO_W){1'b0}}, lo_q});
		end
		if (cmd.ld_dp) begin
			dp_q <= dp_lat - $signed(prod_sh[DP_W-1:0]);
		end
		if (cmd.commit) begin
			ex_out_q  <= x_n;
			in_out_q  <= y_n;
			po_out_q  <= p_n;
			sat_out_q <= hit_n;
		end
	end

	assign excitation_out = ex_out_q;
	assign inhibition_out = in_out_q;
	assign potential_out  = po_out_q;
	assign saturated      = sat_out_q;

endmodule

@@ rtl/relaxation_oscillator_step.sv @@
// One relaxation oscillator advanced by forward Euler in signed Q8.16. A request
// of coupling-weight or unused kind goes from acceptance straight to write-back;
// a potential step and an oscillator step first pass through a chain of states
// that drive the single shared 33x25 multiplier, through which the square, the
// cube, the tanh-scaled inhibition term and the step-size products pass one per
// cycle. The result sits in an output register, so the next request is accepted
// while it waits. Config writes are taken every cycle (cfg_ready stays high);
// index 0 is the stimulus, index 1 the step size.
// Depends on relosc_pkg, relosc_ctrl and relosc_dp.
`timescale 1ns / 1ps

module relaxation_oscillator_step import relosc_pkg::*; #(
	parameter int TANH_ENTRIES = TANH_ENTRIES_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [KIND_W-1:0]            kind,
	input  logic signed [DATA_WIDTH-1:0] coupling_weight,
	input  logic signed [DATA_WIDTH-1:0] global_inhibition,
	input  logic                         last_weight,
	input  logic signed [DATA_WIDTH-1:0] noise_sample,
	input  logic                         lateral_nonnegative,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic signed [DATA_WIDTH-1:0] excitation_out,
	output logic signed [DATA_WIDTH-1:0] inhibition_out,
	output logic signed [DATA_WIDTH-1:0] potential_out,
	output logic                         saturated,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [CFG_AW-1:0]            cfg_index,
	input  logic [DATA_WIDTH-1:0]        cfg_data
);

	dp_cmd_t cmd;
	logic    cfg_we;

	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid && cfg_ready;

	relosc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.kind      (kind),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	relosc_dp #(
		.TANH_ENTRIES (TANH_ENTRIES)
	) u_dp (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cmd                 (cmd),
		.kind                (kind),
		.coupling_weight     (coupling_weight),
		.global_inhibition   (global_inhibition),
		.last_weight         (last_weight),
		.noise_sample        (noise_sample),
		.lateral_nonnegative (lateral_nonnegative),
		.cfg_we              (cfg_we),
		.cfg_index           (cfg_index),
		.cfg_data            (cfg_data),
		.excitation_out      (excitation_out),
		.inhibition_out      (inhibition_out),
		.potential_out       (potential_out),
		.saturated           (saturated)
	);

endmodule
